>>> design/ile_pkg.sv
package ile_pkg;

  localparam int unsigned DEPTH         = 64;
  localparam int unsigned ELEMENT_WIDTH = 32;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned LENGTH_W = 7;

  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_GET    = 2'd2,
    KIND_SET    = 2'd3
  } ile_kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_INS_SHIFT,
    S_INS_LAST,
    S_GET_WAIT,
    S_REM_WAIT,
    S_REM_SHIFT,
    S_RESULT
  } ile_state_e;

  typedef enum logic [2:0] {
    RA_CNT_M1,
    RA_POS,
    RA_IDX_M1,
    RA_IDX_P1,
    RA_IDX_P2
  } ile_raddr_e;

  typedef enum logic [1:0] {
    WA_POS,
    WA_IDX,
    WA_IDX_P1
  } ile_waddr_e;

  typedef enum logic {
    WD_WORD,
    WD_RDATA
  } ile_wdata_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_CNT_M1,
    IDX_POS,
    IDX_DEC,
    IDX_INC
  } ile_idx_e;

  typedef struct packed {
    logic       latch;
    logic       rd_en;
    ile_raddr_e rd_sel;
    logic       wr_en;
    ile_waddr_e wr_sel;
    ile_wdata_e wd_sel;
    ile_idx_e   idx_op;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       res_load;
    logic       res_fail;
    logic       res_take;
    logic       out_load;
  } ile_cmd_t;

  typedef struct packed {
    ile_kind_e kind;
    logic      fail;
    logic      ins_at_end;
    logic      idx_eq_pos;
    logic      idx_p1_ge_cnt;
    logic      idx_p2_ge_cnt;
    logic      out_busy;
  } ile_status_t;

endpackage

>>> design/indexed_list_engine_unit.sv
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_stall_o   kind_i, position_i, element_value_i
// out       output     out_valid_o / out_stall_i status_o, read_value_o, current_length_o
//
// One transaction is processed at a time: in_stall_o is high until it leaves S_RESULT.
// Insert (unless it appends at the end of the list) and remove run a shift loop through
// the store, which has one read and one write port, one entry moved per cycle.
// Reset clears the length and the output valid; the store needs no clearing pass.
// A result waits in the output register while out_stall_i is high; the next request
// may be accepted meanwhile, but it completes only after that result is taken.
module indexed_list_engine_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ile_pkg::KIND_W-1:0]    kind_i,
  input  logic [ile_pkg::POS_W-1:0]     position_i,
  input  logic [ile_pkg::VALUE_W-1:0]   element_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          status_o,
  output logic [ile_pkg::VALUE_W-1:0]   read_value_o,
  output logic [ile_pkg::LENGTH_W-1:0]  current_length_o
);
  import ile_pkg::*;

  ile_cmd_t    cmd;
  ile_status_t status;
  logic        busy;

  assign in_stall_o = busy;

  ile_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  ile_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .kind_i           (kind_i),
    .position_i       (position_i),
    .element_value_i  (element_value_i),
    .out_stall_i      (out_stall_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_valid_o      (out_valid_o),
    .status_bit_o     (status_o),
    .read_value_o     (read_value_o),
    .current_length_o (current_length_o)
  );

endmodule

>>> design/ile_ctrl.sv
module ile_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  ile_pkg::ile_status_t status_i,
  output ile_pkg::ile_cmd_t   cmd_o,
  output logic                busy_o
);
  import ile_pkg::*;

  ile_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.rd_sel = RA_POS;
    cmd_o.wr_sel = WA_POS;
    cmd_o.wd_sel = WD_WORD;
    cmd_o.idx_op = IDX_HOLD;
    busy_o       = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.res_load = 1'b1;
        cmd_o.res_fail = status_i.fail;
        if (status_i.fail) begin
          state_d = S_RESULT;
        end else begin
          case (status_i.kind)
            KIND_INSERT: begin
              if (status_i.ins_at_end) begin
                cmd_o.wr_en   = 1'b1;
                cmd_o.cnt_inc = 1'b1;
                state_d       = S_RESULT;
              end else begin
                cmd_o.rd_en  = 1'b1;
                cmd_o.rd_sel = RA_CNT_M1;
                cmd_o.idx_op = IDX_CNT_M1;
                state_d      = S_INS_SHIFT;
              end
            end
            KIND_REMOVE: begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.idx_op = IDX_POS;
              state_d      = S_REM_WAIT;
            end
            KIND_GET: begin
              cmd_o.rd_en = 1'b1;
              state_d     = S_GET_WAIT;
            end
            KIND_SET: begin
              cmd_o.wr_en = 1'b1;
              state_d     = S_RESULT;
            end
            default: state_d = S_RESULT;
          endcase
        end
      end
      S_INS_SHIFT: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WA_IDX_P1;
        cmd_o.wd_sel = WD_RDATA;
        if (status_i.idx_eq_pos) begin
          state_d = S_INS_LAST;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RA_IDX_M1;
          cmd_o.idx_op = IDX_DEC;
        end
      end
      S_INS_LAST: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        state_d       = S_RESULT;
      end
      S_GET_WAIT: begin
        cmd_o.res_take = 1'b1;
        state_d        = S_RESULT;
      end
      S_REM_WAIT: begin
        cmd_o.res_take = 1'b1;
        if (status_i.idx_p1_ge_cnt) begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_RESULT;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RA_IDX_P1;
          state_d      = S_REM_SHIFT;
        end
      end
      S_REM_SHIFT: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WA_IDX;
        cmd_o.wd_sel = WD_RDATA;
        if (status_i.idx_p2_ge_cnt) begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_RESULT;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RA_IDX_P2;
          cmd_o.idx_op = IDX_INC;
        end
      end
      S_RESULT: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

>>> design/ile_datapath.sv
module ile_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [ile_pkg::KIND_W-1:0]          kind_i,
  input  logic [ile_pkg::POS_W-1:0]           position_i,
  input  logic [ile_pkg::VALUE_W-1:0]         element_value_i,
  input  logic                                out_stall_i,
  input  ile_pkg::ile_cmd_t                   cmd_i,
  output ile_pkg::ile_status_t                status_o,
  output logic                                out_valid_o,
  output logic                                status_bit_o,
  output logic [ile_pkg::VALUE_W-1:0]         read_value_o,
  output logic [ile_pkg::LENGTH_W-1:0]        current_length_o
);
  import ile_pkg::*;

  logic [ELEMENT_WIDTH-1:0] mem_q [DEPTH];
  logic [ELEMENT_WIDTH-1:0] rdata_q;

  logic [KIND_W-1:0]        kind_q;
  logic [POS_W-1:0]         pos_q;
  logic [ELEMENT_WIDTH-1:0] word_q;
  logic [ADDR_W-1:0]        idx_q, idx_d;
  logic [CNT_W-1:0]         count_q, count_d;

  logic                     res_fail_q;
  logic [VALUE_W-1:0]       res_value_q;

  logic                     out_valid_q, out_valid_d;
  logic                     out_status_q;
  logic [VALUE_W-1:0]       out_value_q;
  logic [LENGTH_W-1:0]      out_length_q;

  logic [ADDR_W-1:0]        pos_addr;
  logic [ADDR_W-1:0]        raddr;
  logic [ADDR_W-1:0]        waddr;
  logic [ELEMENT_WIDTH-1:0] wdata;
  logic [CMP_W-1:0]         pos_cmp;
  logic [CMP_W-1:0]         cnt_cmp;
  logic [CMP_W-1:0]         idx_cmp;

  assign pos_addr = ADDR_W'(pos_q);
  assign pos_cmp  = CMP_W'(pos_q);
  assign cnt_cmp  = CMP_W'(count_q);
  assign idx_cmp  = CMP_W'(idx_q);

  always_comb begin
    status_o      = '0;
    status_o.kind = ile_kind_e'(kind_q);
    if (ile_kind_e'(kind_q) == KIND_INSERT) begin
      status_o.fail = (pos_cmp > cnt_cmp) || (count_q == CNT_W'(DEPTH));
    end else begin
      status_o.fail = (pos_cmp >= cnt_cmp);
    end
    status_o.ins_at_end    = (pos_cmp == cnt_cmp);
    status_o.idx_eq_pos    = (idx_cmp == pos_cmp);
    status_o.idx_p1_ge_cnt = ((idx_cmp + CMP_W'(1)) >= cnt_cmp);
    status_o.idx_p2_ge_cnt = ((idx_cmp + CMP_W'(2)) >= cnt_cmp);
    status_o.out_busy      = out_valid_q && out_stall_i;
  end

  always_comb begin
    case (cmd_i.rd_sel)
      RA_CNT_M1: raddr = ADDR_W'(count_q - CNT_W'(1));
      RA_POS:    raddr = pos_addr;
      RA_IDX_M1: raddr = idx_q - ADDR_W'(1);
      RA_IDX_P1: raddr = idx_q + ADDR_W'(1);
      RA_IDX_P2: raddr = idx_q + ADDR_W'(2);
      default:   raddr = pos_addr;
    endcase
    case (cmd_i.wr_sel)
      WA_POS:    waddr = pos_addr;
      WA_IDX:    waddr = idx_q;
      WA_IDX_P1: waddr = idx_q + ADDR_W'(1);
      default:   waddr = pos_addr;
    endcase
    wdata = (cmd_i.wd_sel == WD_RDATA) ? rdata_q : word_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_comb begin
    case (cmd_i.idx_op)
      IDX_HOLD:   idx_d = idx_q;
      IDX_CNT_M1: idx_d = ADDR_W'(count_q - CNT_W'(1));
      IDX_POS:    idx_d = pos_addr;
      IDX_DEC:    idx_d = idx_q - ADDR_W'(1);
      IDX_INC:    idx_d = idx_q + ADDR_W'(1);
      default:    idx_d = idx_q;
    endcase
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CNT_W'(1);
    end
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      kind_q <= kind_i;
      pos_q  <= position_i;
      word_q <= ELEMENT_WIDTH'(element_value_i);
    end
    idx_q <= idx_d;
    if (cmd_i.res_load) begin
      res_fail_q  <= cmd_i.res_fail;
      res_value_q <= '0;
    end else if (cmd_i.res_take) begin
      res_fail_q  <= 1'b0;
      res_value_q <= VALUE_W'(rdata_q);
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_fail_q;
      out_value_q  <= res_value_q;
      out_length_q <= LENGTH_W'(count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_bit_o     = out_status_q;
  assign read_value_o     = out_value_q;
  assign current_length_o = out_length_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("List length exceeds the store depth.");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !(out_valid_q && out_stall_i))
    else $error("A pending result transaction was overwritten.");

  a_inc_not_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_inc |-> (count_q != CNT_W'(DEPTH)) && !cmd_i.cnt_dec)
    else $error("Insert completed on a full list.");

  a_dec_not_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_dec |=> (count_q == $past(count_q) - CNT_W'(1)))
    else $error("Remove did not shorten the list by one.");

endmodule

>>> sim/indexed_list_engine_unit_test.sv
`timescale 1ns / 100ps

module indexed_list_engine_unit_test;
  import ile_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic                status;
    logic [VALUE_W-1:0]  read_value;
    logic [LENGTH_W-1:0] length;
  } list_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [KIND_W-1:0]   kind_i;
  logic [POS_W-1:0]    position_i;
  logic [VALUE_W-1:0]  element_value_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                status_o;
  logic [VALUE_W-1:0]  read_value_o;
  logic [LENGTH_W-1:0] current_length_o;

  logic [ELEMENT_WIDTH-1:0] list_words [DEPTH];
  int unsigned              list_len;
  list_result_t             pending_results [$];
  list_result_t             oldest_result;

  int unsigned burst_left;
  int unsigned stall_run;
  int unsigned stall_roll;
  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned sent_count;
  int unsigned checked_count;
  int unsigned refused_count;
  int unsigned full_refusals;
  int unsigned peak_len;

  indexed_list_engine_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .kind_i           (kind_i),
    .position_i       (position_i),
    .element_value_i  (element_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .read_value_o     (read_value_o),
    .current_length_o (current_length_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic list_result_t apply_list_request(ile_kind_e k, logic [POS_W-1:0] p,
                                                      logic [VALUE_W-1:0] w);
    list_result_t r;
    int unsigned  i;
    r = '0;
    if (k == KIND_INSERT) begin
      if (p > list_len || list_len >= DEPTH) begin
        r.status = 1'b1;
        if (list_len >= DEPTH) full_refusals++;
      end else begin
        for (i = list_len; i > p; i--) list_words[i] = list_words[i - 1];
        list_words[p] = w[ELEMENT_WIDTH-1:0];
        list_len++;
        if (list_len > peak_len) peak_len = list_len;
      end
    end else if (p >= list_len) begin
      r.status = 1'b1;
    end else if (k == KIND_REMOVE) begin
      r.read_value = VALUE_W'(list_words[p]);
      for (i = p; i + 1 < list_len; i++) list_words[i] = list_words[i + 1];
      list_len--;
    end else if (k == KIND_GET) begin
      r.read_value = VALUE_W'(list_words[p]);
    end else begin
      list_words[p] = w[ELEMENT_WIDTH-1:0];
    end
    if (r.status) refused_count++;
    r.length = LENGTH_W'(list_len);
    return r;
  endfunction

  function automatic logic [VALUE_W-1:0] random_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly legal positions with a bias to both ends, plus positions just past the end
  // and fully random ones.
  function automatic logic [POS_W-1:0] pick_position(ile_kind_e k);
    int unsigned roll;
    int unsigned legal;
    roll = $urandom_range(99);
    legal = list_len + ((k == KIND_INSERT) ? 1 : 0);
    if (roll < 6) return POS_W'($urandom_range(2 ** POS_W - 1));
    if (roll < 14 || legal == 0) return POS_W'(legal + $urandom_range(1));
    if (roll < 24) return '0;
    if (roll < 34) return POS_W'(legal - 1);
    return POS_W'($urandom_range(legal - 1));
  endfunction

  task automatic send_request(input ile_kind_e k, input logic [POS_W-1:0] p,
                              input logic [VALUE_W-1:0] w);
    int unsigned gap;
    if (burst_left == 0) begin
      if ($urandom_range(7) == 0) begin
        burst_left = $urandom_range(80, 30);
        gap = 0;
      end else begin
        burst_left = $urandom_range(16, 1);
        gap = $urandom_range(6, 1);
      end
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    kind_i <= k;
    position_i <= p;
    element_value_i <= w;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    burst_left--;
    sent_count++;
    pending_results.push_back(apply_list_request(k, p, w));
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic test_directed_edges();
    send_request(KIND_GET, '0, 32'h1234_5678);
    send_request(KIND_REMOVE, '0, '0);
    send_request(KIND_SET, '0, '1);
    send_request(KIND_INSERT, 7'd1, '1);
    send_request(KIND_INSERT, '0, '0);
    send_request(KIND_INSERT, 7'd1, '1);
    send_request(KIND_INSERT, 7'd1, 32'hA5A5_5A5A);
    send_request(KIND_INSERT, '0, 32'h0000_0001);
    for (int unsigned i = 0; i < 5; i++) send_request(KIND_GET, POS_W'(i), '0);
    send_request(KIND_SET, 7'd3, 32'h8000_0000);
    send_request(KIND_SET, 7'd4, 32'h7FFF_FFFF);
    send_request(KIND_REMOVE, 7'd1, '1);
    send_request(KIND_REMOVE, 7'd2, '0);
    send_request(KIND_REMOVE, '0, '0);
    send_request(KIND_GET, '1, '0);
    send_request(KIND_INSERT, '1, '1);
    send_request(KIND_REMOVE, POS_W'(DEPTH), '0);
    send_request(KIND_REMOVE, '0, '0);
    send_request(KIND_GET, '0, '0);
  endtask

  task automatic test_fill_to_capacity();
    while (list_len < DEPTH) begin
      if ($urandom_range(3) == 0 && list_len != 0) begin
        send_request(KIND_GET, POS_W'($urandom_range(list_len - 1)), random_word());
      end else begin
        send_request(KIND_INSERT, POS_W'($urandom_range(list_len)), random_word());
      end
    end
    send_request(KIND_INSERT, '0, random_word());
    send_request(KIND_INSERT, POS_W'(DEPTH), random_word());
    send_request(KIND_INSERT, POS_W'(DEPTH - 1), random_word());
    send_request(KIND_SET, POS_W'(DEPTH - 1), random_word());
    send_request(KIND_GET, POS_W'(DEPTH - 1), random_word());
    send_request(KIND_GET, POS_W'(DEPTH), random_word());
  endtask

  task automatic test_drain_to_empty();
    while (list_len > 0) begin
      if ($urandom_range(4) == 0) begin
        send_request(KIND_GET, POS_W'($urandom_range(list_len - 1)), random_word());
      end else begin
        send_request(KIND_REMOVE, POS_W'($urandom_range(list_len - 1)), random_word());
      end
    end
    send_request(KIND_REMOVE, '0, random_word());
    send_request(KIND_SET, '0, random_word());
  endtask

  task automatic test_random_mix(input int unsigned n, input int unsigned insert_pct,
                                 input int unsigned remove_pct);
    int unsigned roll;
    ile_kind_e   k;
    repeat (n) begin
      roll = $urandom_range(99);
      if (roll < insert_pct) k = KIND_INSERT;
      else if (roll < insert_pct + remove_pct) k = KIND_REMOVE;
      else if ($urandom_range(1) == 0) k = KIND_GET;
      else k = KIND_SET;
      send_request(k, pick_position(k), random_word());
    end
  endtask

  task automatic test_pause_until_drained();
    wait_for_results();
    test_random_mix(20, 40, 30);
    wait_for_results();
  endtask

  always @(posedge clk_i) begin
    if (stall_run != 0) begin
      stall_run--;
    end else begin
      stall_roll = $urandom_range(15);
      if (stall_roll == 0) begin
        out_stall_i <= 1'b0;
        stall_run = $urandom_range(300, 100);
      end else if (stall_roll == 1) begin
        out_stall_i <= 1'b1;
        stall_run = $urandom_range(40, 20);
      end else if (stall_roll < 8) begin
        out_stall_i <= 1'b1;
        stall_run = $urandom_range(6, 0);
      end else begin
        out_stall_i <= 1'b0;
        stall_run = $urandom_range(10, 0);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      checked_count++;
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
          $display("Unexpected transaction: status %0b read_value %h length %0d",
                   status_o, read_value_o, current_length_o);
        end
      end else begin
        oldest_result = pending_results.pop_front();
        if (status_o !== oldest_result.status || read_value_o !== oldest_result.read_value ||
            current_length_o !== oldest_result.length) begin
          error_count++;
          if (error_count <= REPORT_LIMIT) begin
            $display("Result %0d: expected status %0b value %h length %0d, got %0b %h %0d",
                     checked_count, oldest_result.status, oldest_result.read_value,
                     oldest_result.length, status_o, read_value_o, current_length_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out with %0d results outstanding.", pending_results.size());
      $display("indexed_list_engine_unit verification failed");
      $finish;
    end
  end

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    kind_i = KIND_INSERT;
    position_i = '0;
    element_value_i = '0;
    out_stall_i = 1'b0;
    list_len = 0;
    burst_left = 0;
    stall_run = 0;
    cycle_count = 0;
    error_count = 0;
    sent_count = 0;
    checked_count = 0;
    refused_count = 0;
    full_refusals = 0;
    peak_len = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_edges();
    test_fill_to_capacity();
    test_random_mix(500, 45, 25);
    test_pause_until_drained();
    test_drain_to_empty();
    test_random_mix(500, 35, 35);
    test_fill_to_capacity();
    test_random_mix(400, 25, 45);
    test_drain_to_empty();

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Checked %0d results from %0d requests; %0d requests were refused.",
             checked_count, sent_count, refused_count);
    $display("The list held up to %0d of %0d entries; %0d inserts hit a full list.",
             peak_len, DEPTH, full_refusals);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("indexed_list_engine_unit verification clean");
    end else begin
      $display("indexed_list_engine_unit verification failed");
    end
    $finish;
  end

endmodule
